FILE: rtl/core/stack_machine_integer_execute_core_assert.svh
// Assertion macros for the stack machine execute core.
`ifndef STACK_MACHINE_INTEGER_EXECUTE_CORE_ASSERT_SVH
`define STACK_MACHINE_INTEGER_EXECUTE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SMIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/smie_pkg.sv
// Shared types, codes and ALU function for the stack machine execute core.
package smie_pkg;

    typedef enum logic [5:0] {
        OP_NOP      = 6'd0,
        OP_ALLOCA   = 6'd1,
        OP_DISCARD  = 6'd2,
        OP_STACKROT = 6'd3,
        OP_GALLOCA  = 6'd4,
        OP_GLOAD    = 6'd5,
        OP_GSTORE   = 6'd6,
        OP_EXIT     = 6'd7,
        OP_EXITPOP  = 6'd8,
        OP_JMP      = 6'd9,
        OP_JN       = 6'd10,
        OP_JZ       = 6'd11,
        OP_LOAD     = 6'd12,
        OP_STORE    = 6'd13,
        OP_ILOAD    = 6'd14,
        OP_NNEG     = 6'd15,
        OP_NNOT     = 6'd16,
        OP_NADD     = 6'd17,
        OP_NSUB     = 6'd18,
        OP_NMUL     = 6'd19,
        OP_NDIV     = 6'd20,
        OP_NREM     = 6'd21,
        OP_NSHL     = 6'd22,
        OP_NSHR     = 6'd23,
        OP_NAND     = 6'd24,
        OP_NOR      = 6'd25,
        OP_NXOR     = 6'd26,
        OP_NCMPZ    = 6'd27,
        OP_NCMPEQ   = 6'd28,
        OP_NCMPNE   = 6'd29,
        OP_NCMPLE   = 6'd30,
        OP_NCMPGE   = 6'd31,
        OP_NCMPLT   = 6'd32,
        OP_NCMPGT   = 6'd33,
        OP_BNOT     = 6'd34,
        OP_BAND     = 6'd35,
        OP_BOR      = 6'd36,
        OP_BXOR     = 6'd37,
        OP_VCMPEQ   = 6'd38,
        OP_VCMPNE   = 6'd39,
        OP_VCMPLT   = 6'd40,
        OP_VCMPLE   = 6'd41,
        OP_VCMPGT   = 6'd42,
        OP_VCMPGE   = 6'd43
    } op_t;

    localparam logic [5:0] OP_LAST = 6'd43;

    typedef enum logic [2:0] {
        F_OK     = 3'd0,
        F_DIV0   = 3'd1,
        F_OVER   = 3'd2,
        F_UNDER  = 3'd3,
        F_INDEX  = 3'd4,
        F_OPCODE = 3'd5
    } fault_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_ROT_T,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_PUSH,
        ST_BIN,
        ST_MUL,
        ST_DIV,
        ST_WB,
        ST_REFILL,
        ST_REFILL_W,
        ST_RESP
    } state_t;

    // register index of checks_enabled
    localparam logic REG_CHECKS = 1'b0;

    typedef struct packed {
        logic start;
        logic is_rem;
    } div_ctl_t;

    // Combinational two-operand ops; a is below the top, b is the top.
    function automatic logic [63:0] alu_op(op_t op, logic [63:0] a, logic [63:0] b);
        logic lt_ab;
        logic lt_ba;
        logic [63:0] r;
        lt_ab = $signed(a) < $signed(b);
        lt_ba = $signed(b) < $signed(a);
        case (op)
            OP_NADD:                r = a + b;
            OP_NSUB:                r = a - b;
            OP_NSHL:                r = a << b[5:0];
            OP_NSHR:                r = $signed(a) >>> b[5:0];
            OP_NAND:                r = a & b;
            OP_NOR:                 r = a | b;
            OP_NXOR, OP_BXOR:       r = a ^ b;
            OP_NCMPEQ, OP_VCMPEQ:   r = {63'b0, a == b};
            OP_NCMPNE, OP_VCMPNE:   r = {63'b0, a != b};
            OP_NCMPLE, OP_VCMPLE:   r = {63'b0, !lt_ba};
            OP_NCMPGE, OP_VCMPGE:   r = {63'b0, !lt_ab};
            OP_NCMPLT, OP_VCMPLT:   r = {63'b0, lt_ab};
            OP_NCMPGT, OP_VCMPGT:   r = {63'b0, lt_ba};
            OP_BAND:                r = {63'b0, (a != 64'b0) && (b != 64'b0)};
            OP_BOR:                 r = {63'b0, (a != 64'b0) || (b != 64'b0)};
            default:                r = 64'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/smie_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
module smie_div
    import smie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_ctl_t    ctl,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic [64:0] r_reg, r_next;
    logic [63:0] ub_reg, ub_next;
    logic        neg_reg, neg_next;
    logic        rem_reg, rem_next;
    logic [63:0] res_reg, res_next;

    logic [64:0] r_sh;
    logic        ge;
    logic [64:0] r_new;
    logic [63:0] val;

    assign r_sh  = {r_reg[63:0], q_reg[63]};
    assign ge    = r_sh >= {1'b0, ub_reg};
    assign r_new = ge ? (r_sh - {1'b0, ub_reg}) : r_sh;
    assign val   = rem_reg ? r_new[63:0] : {q_reg[62:0], ge};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        ub_next   = ub_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        if (ctl.start)
        begin
            if (divisor == 64'b0)
            begin
                // zero divisor with checks off
                res_next  = ctl.is_rem ? dividend : '1;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = 6'd0;
                q_next    = dividend[63] ? (64'b0 - dividend) : dividend;
                r_next    = 65'b0;
                ub_next   = divisor[63] ? (64'b0 - divisor) : divisor;
                rem_next  = ctl.is_rem;
                neg_next  = ctl.is_rem ? dividend[63] : (dividend[63] ^ divisor[63]);
            end
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[62:0], ge};
            r_next   = r_new;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (64'b0 - val) : val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        ub_reg  <= ub_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: rtl/core/stack_machine_integer_execute_core.sv
// Stack machine execute core: operand stack and globals in synchronous RAM.
// An instruction is taken with start while busy is low; its single result appears
// for one cycle with done, in the cycle in which busy falls, and the receiver cannot
// stall it. The steps from accept to the result follow the stack RAM read-modify-write:
// ops with no RAM read (NOP, JMP, EXIT, ILOAD, unary ops, GALLOCA), faults and steps
// while halted go straight from execute to the response; LOAD/GLOAD add a push state;
// pops re-read the new top into the top-of-stack register (skipped when the stack ends
// empty); ALU binary ops read the second operand, then write back; NMUL forms three
// 32x32 partial products on one multiplier; NDIV/NREM run the divider, one quotient bit
// per cycle (a zero divisor with checks off skips the quotient loop); ALLOCA writes one
// zero per slot, and STACKROT does one RAM read and write per slot moved. After an exit
// or a fault the core stays halted until reset. No clearing pass runs after reset.
module stack_machine_integer_execute_core
    import smie_pkg::*;
#(
    parameter int STACK_DEPTH  = 256,
    parameter int GLOBAL_COUNT = 64,
    parameter int PC_WIDTH     = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [5:0]         func,
    input  logic [15:0]        operand,
    output logic               done,
    output logic [15:0]        next_pc,
    output logic               halted,
    output logic               exit_status,
    output logic [2:0]         fault,
    output logic signed [63:0] top_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int GAW = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;
    localparam int GW  = $clog2(GLOBAL_COUNT + 1);
    localparam logic [31:0] SD32 = 32'(STACK_DEPTH);
    localparam logic [31:0] GC32 = 32'(GLOBAL_COUNT);

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [15:0]         opd_reg, opd_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [GW-1:0]       gcnt_reg, gcnt_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;
    logic                stopped_reg, stopped_next;
    logic                chk_reg, chk_next;
    logic [63:0]         tos_reg, tos_next;
    logic [63:0]         opa_reg, opa_next;
    logic [63:0]         tmp_reg, tmp_next;
    logic [63:0]         res_reg, res_next;
    logic [DW-1:0]       cnt_reg, cnt_next;
    fault_t              fault_reg, fault_next;
    logic                exst_reg, exst_next;
    logic                done_reg, done_next;
    logic [15:0]         npc_out_reg;
    logic                halted_out_reg;
    logic                exst_out_reg;
    logic [2:0]          fault_out_reg;
    logic [63:0]         top_out_reg;

    // stack RAM
    logic [63:0]         stack_mem [STACK_DEPTH];
    logic                s_we;
    logic [SAW-1:0]      s_waddr, s_raddr;
    logic [63:0]         s_wdata, s_rdata;
    // global RAM
    logic [63:0]         glob_mem [GLOBAL_COUNT];
    logic                g_we;
    logic [GAW-1:0]      g_waddr, g_raddr;
    logic [63:0]         g_wdata, g_rdata;

    logic [31:0] d32, a32, g32, c32, d_m1, d_m2, d_pc, c_p1;
    logic [31:0] pc_ext;
    fault_t      exec_fault;
    logic        tos_nz;
    logic        jump_taken;
    logic [PC_WIDTH-1:0] npc_sel;
    logic [63:0] unary_val;
    logic [63:0] push_val;
    logic [31:0] mul_x, mul_y;
    logic [63:0] prod;
    div_ctl_t    div_ctl;
    logic        div_done;
    logic [63:0] div_res;
    logic        cfg_wr;

    assign d32    = 32'(depth_reg);
    assign a32    = 32'(opd_reg);
    assign g32    = 32'(gcnt_reg);
    assign c32    = 32'(cnt_reg);
    assign d_m1   = d32 - 32'd1;
    assign d_m2   = d32 - 32'd2;
    assign d_pc   = d32 + c32;
    assign c_p1   = c32 + 32'd1;
    assign pc_ext = 32'(pc_reg);
    assign tos_nz = tos_reg != 64'b0;

    assign jump_taken = (op_reg == OP_JMP) ||
                        ((op_reg == OP_JN) && tos_nz) ||
                        ((op_reg == OP_JZ) && !tos_nz);
    assign npc_sel = jump_taken ? PC_WIDTH'(opd_reg) : (pc_reg + 1'b1);

    assign push_val = (op_reg == OP_GLOAD) ? g_rdata : s_rdata;

    // shared 32x32 multiplier for the three partial products of NMUL
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd1:    begin mul_x = opa_reg[63:32]; mul_y = tos_reg[31:0];  end
            2'd2:    begin mul_x = opa_reg[31:0];  mul_y = tos_reg[63:32]; end
            default: begin mul_x = opa_reg[31:0];  mul_y = tos_reg[31:0];  end
        endcase
    end
    assign prod = 64'(mul_x) * 64'(mul_y);

    always_comb
    begin
        case (op_reg)
            OP_NNEG: unary_val = 64'b0 - tos_reg;
            OP_NNOT: unary_val = ~tos_reg;
            default: unary_val = {63'b0, !tos_nz};
        endcase
    end

    // fault checks: opcode first, then in order underflow, index, overflow, divide by zero
    always_comb
    begin
        exec_fault = F_OK;
        if (op_reg > OP_LAST)
            exec_fault = F_OPCODE;
        else
        begin
            case (op_reg)
                OP_NOP, OP_EXIT, OP_JMP: exec_fault = F_OK;
                OP_ALLOCA:
                    if (d32 + a32 > SD32) exec_fault = F_OVER;
                OP_DISCARD:
                    if (a32 > d32) exec_fault = F_UNDER;
                OP_STACKROT:
                    if (a32 >= d32) exec_fault = F_INDEX;
                OP_GALLOCA:
                    if (g32 >= GC32) exec_fault = F_OVER;
                OP_GLOAD:
                    if (a32 >= g32) exec_fault = F_INDEX;
                    else if (d32 >= SD32) exec_fault = F_OVER;
                OP_GSTORE:
                    if (d32 < 32'd1) exec_fault = F_UNDER;
                    else if (a32 >= g32) exec_fault = F_INDEX;
                OP_EXITPOP, OP_JN, OP_JZ, OP_NNEG, OP_NNOT, OP_NCMPZ, OP_BNOT:
                    if (d32 < 32'd1) exec_fault = F_UNDER;
                OP_LOAD:
                    if (a32 >= d32) exec_fault = F_INDEX;
                    else if (d32 >= SD32) exec_fault = F_OVER;
                OP_STORE:
                    if (d32 < 32'd1) exec_fault = F_UNDER;
                    else if (a32 >= d_m1) exec_fault = F_INDEX;
                OP_ILOAD:
                    if (d32 >= SD32) exec_fault = F_OVER;
                default:
                    if (d32 < 32'd2) exec_fault = F_UNDER;
                    else if ((op_reg == OP_NDIV || op_reg == OP_NREM) && chk_reg && !tos_nz)
                        exec_fault = F_DIV0;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start) state_next = ST_EXEC;
            ST_EXEC:
                if (stopped_reg || exec_fault != F_OK)
                    state_next = ST_RESP;
                else
                begin
                    case (op_reg)
                        OP_ALLOCA:
                            state_next = (opd_reg == 16'd0) ? ST_RESP : ST_FILL;
                        OP_DISCARD, OP_GSTORE, OP_EXITPOP, OP_JN, OP_JZ, OP_STORE:
                            state_next = ST_REFILL;
                        OP_STACKROT:
                            state_next = ST_ROT_T;
                        OP_GLOAD, OP_LOAD:
                            state_next = ST_PUSH;
                        OP_NOP, OP_GALLOCA, OP_EXIT, OP_JMP, OP_ILOAD,
                        OP_NNEG, OP_NNOT, OP_NCMPZ, OP_BNOT:
                            state_next = ST_RESP;
                        default:
                            state_next = ST_BIN;
                    endcase
                end
            ST_FILL:
                if (c32 == a32 - 32'd1) state_next = ST_RESP;
            ST_ROT_T:
                state_next = ST_ROT_RD;
            ST_ROT_RD:
                state_next = (c_p1 < d32) ? ST_ROT_WR : ST_RESP;
            ST_ROT_WR:
                state_next = ST_ROT_RD;
            ST_PUSH:
                state_next = ST_RESP;
            ST_BIN:
                if (op_reg == OP_NMUL) state_next = ST_MUL;
                else if (op_reg == OP_NDIV || op_reg == OP_NREM) state_next = ST_DIV;
                else state_next = ST_WB;
            ST_MUL:
                if (cnt_reg[1:0] == 2'd2) state_next = ST_WB;
            ST_DIV:
                if (div_done) state_next = ST_WB;
            ST_WB:
                state_next = ST_RESP;
            ST_REFILL:
                state_next = (depth_reg != '0) ? ST_REFILL_W : ST_RESP;
            ST_REFILL_W:
                state_next = ST_RESP;
            ST_RESP:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        op_next      = op_reg;
        opd_next     = opd_reg;
        depth_next   = depth_reg;
        gcnt_next    = gcnt_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        tos_next     = tos_reg;
        opa_next     = opa_reg;
        tmp_next     = tmp_reg;
        res_next     = res_reg;
        cnt_next     = cnt_reg;
        fault_next   = fault_reg;
        exst_next    = exst_reg;
        done_next    = 1'b0;
        s_we         = 1'b0;
        s_waddr      = '0;
        s_wdata      = 64'b0;
        s_raddr      = '0;
        g_we         = 1'b0;
        g_waddr      = '0;
        g_wdata      = 64'b0;
        g_raddr      = '0;
        div_ctl      = '0;
        case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    op_next    = op_t'(func);
                    opd_next   = operand;
                    fault_next = F_OK;
                    exst_next  = 1'b0;
                end
            ST_EXEC:
                if (!stopped_reg)
                begin
                    if (exec_fault != F_OK)
                    begin
                        fault_next   = exec_fault;
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        if (op_reg != OP_EXIT && op_reg != OP_EXITPOP)
                            pc_next = npc_sel;
                        case (op_reg)
                            OP_ALLOCA:
                                cnt_next = '0;
                            OP_DISCARD:
                                depth_next = DW'(d32 - a32);
                            OP_STACKROT:
                            begin
                                s_raddr  = a32[SAW-1:0];
                                cnt_next = DW'(a32);
                            end
                            OP_GALLOCA:
                            begin
                                g_we      = 1'b1;
                                g_waddr   = g32[GAW-1:0];
                                gcnt_next = gcnt_reg + 1'b1;
                            end
                            OP_GLOAD:
                                g_raddr = a32[GAW-1:0];
                            OP_GSTORE:
                            begin
                                g_we       = 1'b1;
                                g_waddr    = a32[GAW-1:0];
                                g_wdata    = tos_reg;
                                depth_next = depth_reg - 1'b1;
                            end
                            OP_EXIT:
                            begin
                                exst_next    = opd_reg != 16'd0;
                                stopped_next = 1'b1;
                            end
                            OP_EXITPOP:
                            begin
                                exst_next    = tos_nz;
                                stopped_next = 1'b1;
                                depth_next   = depth_reg - 1'b1;
                            end
                            OP_JN, OP_JZ:
                                depth_next = depth_reg - 1'b1;
                            OP_LOAD:
                                s_raddr = a32[SAW-1:0];
                            OP_STORE:
                            begin
                                s_we       = 1'b1;
                                s_waddr    = a32[SAW-1:0];
                                s_wdata    = tos_reg;
                                depth_next = depth_reg - 1'b1;
                            end
                            OP_ILOAD:
                            begin
                                s_we       = 1'b1;
                                s_waddr    = d32[SAW-1:0];
                                s_wdata    = {48'b0, opd_reg};
                                tos_next   = {48'b0, opd_reg};
                                depth_next = depth_reg + 1'b1;
                            end
                            OP_NNEG, OP_NNOT, OP_NCMPZ, OP_BNOT:
                            begin
                                s_we     = 1'b1;
                                s_waddr  = d_m1[SAW-1:0];
                                s_wdata  = unary_val;
                                tos_next = unary_val;
                            end
                            OP_NOP, OP_JMP: ;
                            default:
                                s_raddr = d_m2[SAW-1:0];
                        endcase
                    end
                end
            ST_FILL:
            begin
                s_we     = 1'b1;
                s_waddr  = d_pc[SAW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (c32 == a32 - 32'd1)
                begin
                    depth_next = DW'(d32 + a32);
                    tos_next   = 64'b0;
                end
            end
            ST_ROT_T:
                tmp_next = s_rdata;
            ST_ROT_RD:
                if (c_p1 < d32)
                    s_raddr = c_p1[SAW-1:0];
                else
                begin
                    // rotated value lands on top
                    s_we     = 1'b1;
                    s_waddr  = d_m1[SAW-1:0];
                    s_wdata  = tmp_reg;
                    tos_next = tmp_reg;
                end
            ST_ROT_WR:
            begin
                s_we     = 1'b1;
                s_waddr  = c32[SAW-1:0];
                s_wdata  = s_rdata;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_PUSH:
            begin
                s_we       = 1'b1;
                s_waddr    = d32[SAW-1:0];
                s_wdata    = push_val;
                tos_next   = push_val;
                depth_next = depth_reg + 1'b1;
            end
            ST_BIN:
                if (op_reg == OP_NMUL)
                begin
                    opa_next = s_rdata;
                    cnt_next = '0;
                end
                else if (op_reg == OP_NDIV || op_reg == OP_NREM)
                begin
                    div_ctl.start  = 1'b1;
                    div_ctl.is_rem = op_reg == OP_NREM;
                end
                else
                    res_next = alu_op(op_reg, s_rdata, tos_reg);
            ST_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd0)
                    res_next = prod;
                else
                    res_next = res_reg + {prod[31:0], 32'b0};
            end
            ST_DIV:
                if (div_done) res_next = div_res;
            ST_WB:
            begin
                s_we       = 1'b1;
                s_waddr    = d_m2[SAW-1:0];
                s_wdata    = res_reg;
                tos_next   = res_reg;
                depth_next = depth_reg - 1'b1;
            end
            ST_REFILL:
                s_raddr = d_m1[SAW-1:0];
            ST_REFILL_W:
                tos_next = s_rdata;
            ST_RESP:
                done_next = 1'b1;
            default: ;
        endcase
    end

    smie_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (s_rdata),
        .divisor  (tos_reg),
        .done     (div_done),
        .result   (div_res)
    );

    always_ff @(posedge clk)
    begin
        if (s_we)
            stack_mem[s_waddr] <= s_wdata;
        s_rdata <= stack_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            glob_mem[g_waddr] <= g_wdata;
        g_rdata <= glob_mem[g_raddr];
    end

    // configuration port
    assign cfg_wr   = psel && penable && pwrite;
    assign chk_next = (cfg_wr && paddr[2] == REG_CHECKS) ? pwdata[0] : chk_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CHECKS) ? {31'b0, chk_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            gcnt_reg    <= '0;
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
            chk_reg     <= 1'b1;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            gcnt_reg    <= gcnt_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
            chk_reg     <= chk_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        opd_reg   <= opd_next;
        tos_reg   <= tos_next;
        opa_reg   <= opa_next;
        tmp_reg   <= tmp_next;
        res_reg   <= res_next;
        fault_reg <= fault_next;
        exst_reg  <= exst_next;
        if (state_reg == ST_RESP)
        begin
            npc_out_reg    <= pc_ext[15:0];
            halted_out_reg <= stopped_reg;
            exst_out_reg   <= exst_reg;
            fault_out_reg  <= fault_reg;
            top_out_reg    <= (depth_reg != '0) ? tos_reg : 64'b0;
        end
    end

    assign busy        = state_reg != ST_IDLE;
    assign done        = done_reg;
    assign next_pc     = npc_out_reg;
    assign halted      = halted_out_reg;
    assign exit_status = exst_out_reg;
    assign fault       = fault_out_reg;
    assign top_value   = $signed(top_out_reg);

`include "stack_machine_integer_execute_core_assert.svh"

    `SMIE_ASSERT_NEXT(a_resp_done, state_reg == ST_RESP, done_reg, "result strobe missing")
    `SMIE_ASSERT_NEXT(a_stop_sticky, stopped_reg, stopped_reg, "halt flag cleared")
    `SMIE_ASSERT_NOW(a_depth_range, 1'b1, 32'(depth_reg) <= SD32, "stack depth out of range")
    `SMIE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "transfer accepted but core idle")

endmodule
